// ===== src/alpha_crossfade_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Alpha crossfade sequencer assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef ALPHA_CROSSFADE_SEQUENCER_DEFINES_SVH
`define ALPHA_CROSSFADE_SEQUENCER_DEFINES_SVH

// Clocked assertion with reset disable and a custom message.
`define ACS_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion with a generic message.
`define ACS_ASSERT(name, prop) \
  `ACS_ASSERT_MSG(name, prop, "alpha crossfade sequencer check failed")

`endif

// ===== src/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha crossfade sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned NumW   = LevelW + SpanW + 1;
  localparam int unsigned CntW   = $clog2(LevelW);

  localparam logic [LevelW-1:0] LevelMax = 8'hFF;
  localparam logic [SpanW-1:0]  SpanMax  = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_RESET   = 2'd1,
    FUNC_REVERSE = 2'd2,
    FUNC_TICK    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_STARTING = 2'd1,
    PH_RUNNING  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ELAPSED = 3'd1,
    ST_DECIDE  = 3'd2,
    ST_MUL     = 3'd3,
    ST_DIV     = 3'd4,
    ST_OUT     = 3'd5
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/alpha_crossfade_sequencer.sv =====
// ----------------------------------------------------------------------------
// Alpha crossfade sequencer
// Two-layer linear fade sequencer driven by start, reset, reverse and frame
// tick commands, with a shared serial divider for the interpolation.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                     Contents
// cfg       in         cfg_valid_i/ready_o/data_i  cross_fade register
// s_axis    in         tvalid/tready/tdata/tuser   command request
// m_axis    out        tvalid/tready/tdata         layer draw result
//
// A frame tick during a running fade with a nonzero span also runs the
// eight quotient steps of the serial divider; every other request skips the
// divider. One request is in work at a time, and the next is taken once the
// result sits in the output register. A stalled output holds the sequencer
// before its output step. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module alpha_crossfade_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // [0] cross_fade
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] duration_ms, [47:16] now_ms
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [7:0] alpha, [8] finished,
                                      // [9] first_enable, [17:10] first_alpha,
                                      // [18] second_enable,
                                      // [26:19] second_alpha,
                                      // [27] redraw_request, [31:28] zero
);

  localparam int unsigned LW = acs_pkg::LevelW;
  localparam int unsigned SW = acs_pkg::SpanW;
  localparam int unsigned TW = acs_pkg::TimeW;

  acs_pkg::state_e        state_q, state_d;
  acs_pkg::phase_e        phase_q;
  acs_pkg::func_e         func_q;
  logic [SW-1:0]          dur_q;
  logic [TW-1:0]          now_q;
  logic                   cross_fade_q;
  logic [LW-1:0]          from_q, to_q, level_q;
  logic [SW-1:0]          span_q, orig_q;
  logic                   back_q;
  logic [TW-1:0]          stamp_q;
  logic [SW-1:0]          el_q;
  logic                   done_q;
  logic                   redraw_q;
  logic                   up_q;
  logic                   m_valid_q;
  logic [31:0]            m_data_q;

  logic [TW-1:0]          diff;
  logic [SW-1:0]          el_sat;
  logic [SW-1:0]          eff;
  logic [LW-1:0]          dlev;
  logic [LW+SW-1:0]       prod;
  logic [acs_pkg::NumW-1:0] numer;
  logic                   up;
  logic                   new_back;
  logic                   load_out;
  logic                   div_start;
  logic [LW-1:0]          quot;
  acs_pkg::div_stat_t     div_stat;

  logic                   fin;
  logic                   e1, e2, rd;
  logic [LW-1:0]          a1, a2;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == acs_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign diff   = now_q - stamp_q;
  assign el_sat = (|diff[TW-1:SW]) ? acs_pkg::SpanMax : diff[SW-1:0];
  assign eff    = (el_q < span_q) ? el_q : span_q;
  assign up     = (to_q >= from_q);
  assign dlev   = up ? (to_q - from_q) : (from_q - to_q);
  assign prod   = (LW+SW)'(dlev) * (LW+SW)'(eff);
  assign numer  = up ? {1'b0, prod}
                     : {1'b0, prod} + acs_pkg::NumW'(span_q) - 1'b1;
  assign new_back = ~back_q;
  assign load_out = (state_q == acs_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
  assign div_start = (state_q == acs_pkg::ST_MUL);

  acs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (numer),
    .denom_i (span_q),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      acs_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = acs_pkg::ST_ELAPSED;
        end
      end
      acs_pkg::ST_ELAPSED: begin
        state_d = acs_pkg::ST_DECIDE;
      end
      acs_pkg::ST_DECIDE: begin
        if (func_q == acs_pkg::FUNC_TICK && phase_q == acs_pkg::PH_RUNNING &&
            span_q != '0) begin
          state_d = acs_pkg::ST_MUL;
        end else begin
          state_d = acs_pkg::ST_OUT;
        end
      end
      acs_pkg::ST_MUL: begin
        state_d = acs_pkg::ST_DIV;
      end
      acs_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = acs_pkg::ST_OUT;
        end
      end
      acs_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = acs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = acs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fin = 1'b0;
    e1  = 1'b0;
    e2  = 1'b0;
    a1  = '0;
    a2  = '0;
    rd  = redraw_q;
    if (func_q != acs_pkg::FUNC_TICK) begin
      fin = (phase_q == acs_pkg::PH_NONE);
    end else if (done_q) begin
      fin = 1'b1;
      e1  = !cross_fade_q || (level_q == '0);
      e2  = (level_q == acs_pkg::LevelMax);
      a1  = acs_pkg::LevelMax;
      a2  = acs_pkg::LevelMax;
      rd  = 1'b0;
    end else begin
      e1  = 1'b1;
      a1  = cross_fade_q ? (acs_pkg::LevelMax - level_q) : acs_pkg::LevelMax;
      e2  = (level_q != '0);
      a2  = level_q;
      rd  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acs_pkg::ST_IDLE;
      phase_q      <= acs_pkg::PH_NONE;
      cross_fade_q <= 1'b0;
      from_q       <= '0;
      to_q         <= '0;
      level_q      <= '0;
      span_q       <= '0;
      orig_q       <= '0;
      back_q       <= 1'b0;
      stamp_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        cross_fade_q <= cfg_data_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        acs_pkg::ST_DECIDE: begin
          case (func_q)
            acs_pkg::FUNC_START: begin
              from_q  <= '0;
              to_q    <= acs_pkg::LevelMax;
              level_q <= '0;
              span_q  <= dur_q;
              orig_q  <= dur_q;
              back_q  <= 1'b0;
              phase_q <= acs_pkg::PH_STARTING;
            end
            acs_pkg::FUNC_RESET: begin
              level_q <= '0;
              phase_q <= acs_pkg::PH_NONE;
            end
            acs_pkg::FUNC_REVERSE: begin
              if (el_q > span_q) begin
                if (to_q == '0) begin
                  from_q  <= '0;
                  to_q    <= acs_pkg::LevelMax;
                  level_q <= '0;
                  back_q  <= 1'b0;
                end else begin
                  from_q  <= acs_pkg::LevelMax;
                  to_q    <= '0;
                  level_q <= acs_pkg::LevelMax;
                  back_q  <= 1'b1;
                end
                span_q <= dur_q;
                orig_q <= dur_q;
              end else begin
                back_q <= new_back;
                from_q <= level_q;
                to_q   <= new_back ? '0 : acs_pkg::LevelMax;
                if (new_back) begin
                  span_q <= el_q;
                end else begin
                  span_q <= (orig_q > el_q) ? (orig_q - el_q) : '0;
                end
              end
              phase_q <= acs_pkg::PH_STARTING;
            end
            acs_pkg::FUNC_TICK: begin
              if (phase_q == acs_pkg::PH_STARTING) begin
                stamp_q <= now_q;
                phase_q <= acs_pkg::PH_RUNNING;
              end else if (phase_q == acs_pkg::PH_RUNNING && span_q == '0) begin
                level_q <= to_q;
              end
            end
            default: begin
            end
          endcase
        end
        acs_pkg::ST_DIV: begin
          if (div_stat.done) begin
            level_q <= up_q ? (from_q + quot) : (from_q - quot);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= acs_pkg::func_e'(s_axis_tuser);
      dur_q  <= s_axis_tdata[SW-1:0];
      now_q  <= s_axis_tdata[SW+TW-1:SW];
    end
    if (state_q == acs_pkg::ST_ELAPSED) begin
      el_q <= el_sat;
    end
    if (state_q == acs_pkg::ST_DECIDE) begin
      redraw_q <= !(func_q == acs_pkg::FUNC_REVERSE && el_q <= span_q);
      if (phase_q == acs_pkg::PH_STARTING) begin
        done_q <= 1'b0;
      end else if (phase_q == acs_pkg::PH_RUNNING) begin
        done_q <= (span_q == '0) || (el_q >= span_q);
      end else begin
        done_q <= 1'b1;
      end
    end
    if (state_q == acs_pkg::ST_MUL) begin
      up_q <= up;
    end
    if (load_out) begin
      m_data_q <= {4'b0000, rd, a2, e2, a1, e1, fin, level_q};
    end
  end

endmodule

// ===== src/acs_div.sv =====
// ----------------------------------------------------------------------------
// Alpha crossfade sequencer divider
// Restoring divider that produces one quotient bit per cycle for an
// eight-bit quotient, with one compare-and-subtract unit.
// ----------------------------------------------------------------------------
module acs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [acs_pkg::NumW-1:0]      numer_i,
  input  logic [acs_pkg::SpanW-1:0]     denom_i,
  output logic [acs_pkg::LevelW-1:0]    quot_o,
  output acs_pkg::div_stat_t            stat_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [acs_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [acs_pkg::SpanW-1:0]     rem_q, rem_d;
  logic [acs_pkg::SpanW-1:0]     den_q, den_d;
  logic [acs_pkg::LevelW-1:0]    bits_q, bits_d;
  logic [acs_pkg::SpanW:0]       trial;
  logic [acs_pkg::SpanW:0]       diff;
  logic                          ge;

  assign trial = {rem_q, bits_q[acs_pkg::LevelW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = numer_i[acs_pkg::NumW-2:acs_pkg::LevelW];
      bits_d = numer_i[acs_pkg::LevelW-1:0];
      den_d  = denom_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[acs_pkg::SpanW-1:0] : trial[acs_pkg::SpanW-1:0];
      bits_d = {bits_q[acs_pkg::LevelW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == acs_pkg::CntW'(acs_pkg::LevelW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
  end

  assign quot_o      = bits_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== src/acs_checker.sv =====
// ----------------------------------------------------------------------------
// Alpha crossfade sequencer checker
// Port-level assertions on request handling and result consistency.
// ----------------------------------------------------------------------------
`include "alpha_crossfade_sequencer_defines.svh"

module acs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic       res_fin;
  logic       res_first_en;
  logic       res_second_en;
  logic       full_ok;
  logic       follow_ok;

  assign res_fin       = m_axis_tdata[8];
  assign res_first_en  = m_axis_tdata[9];
  assign res_second_en = m_axis_tdata[18];
  assign full_ok       = (m_axis_tdata[7:0] == 8'hFF) && (m_axis_tdata[26:19] == 8'hFF);
  assign follow_ok     = (m_axis_tdata[26:19] == m_axis_tdata[7:0]);

  // A taken request keeps the input closed while it is in work.
  `ACS_ASSERT(a_one_in_work, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // A finished tick shows the second layer only at full level.
  `ACS_ASSERT(a_full_second, (m_axis_tvalid && res_fin && res_second_en) |-> full_ok)

  // During a fade the second layer alpha follows the level.
  `ACS_ASSERT(a_fade_alpha, (m_axis_tvalid && res_first_en && !res_fin) |-> follow_ok)

  `ACS_ASSERT_MSG(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind alpha_crossfade_sequencer acs_checker u_acs_checker (.*);
